// ===== rtl/atrp_pkg.sv =====
// Shared types, codes and helpers for the AT reply parser.
package atrp_pkg;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CMD  = 2'd1,
        OP_DATA = 2'd2,
        OP_LINK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_UNSET = 2'd0,
        MODE_CMD   = 2'd1,
        MODE_PASS  = 2'd2
    } mode_t;

    typedef enum logic [4:0] {
        KIND_NONE    = 5'd0,
        KIND_OK      = 5'd1,
        KIND_ERROR   = 5'd2,
        KIND_ADCN    = 5'd3,
        KIND_ADDR    = 5'd4,
        KIND_FAIL    = 5'd5,
        KIND_BIND    = 5'd6,
        KIND_CLASS   = 5'd7,
        KIND_CMODE   = 5'd8,
        KIND_DISC    = 5'd9,
        KIND_INQ     = 5'd10,
        KIND_INQM    = 5'd11,
        KIND_IAC     = 5'd12,
        KIND_IPSCAN  = 5'd13,
        KIND_MPIO    = 5'd14,
        KIND_MRAD    = 5'd15,
        KIND_NAME    = 5'd16,
        KIND_POLAR   = 5'd17,
        KIND_PSWD    = 5'd18,
        KIND_ROLE    = 5'd19,
        KIND_RNAME   = 5'd20,
        KIND_SENM    = 5'd21,
        KIND_SNIFF   = 5'd22,
        KIND_STATE   = 5'd23,
        KIND_UART    = 5'd24,
        KIND_VERSION = 5'd25
    } kind_t;

    // Recognizer positions; most names spell the characters matched so far.
    typedef enum logic [7:0] {
        POS_IDLE    = 8'd0,
        POS_PLUS    = 8'd1,
        POS_O       = 8'd10,
        POS_OK      = 8'd11,
        POS_E       = 8'd20,
        POS_ERR_D1  = 8'd21,
        POS_ERR_D2  = 8'd22,
        POS_A       = 8'd25,
        POS_AD      = 8'd26,
        POS_ADC     = 8'd27,
        POS_ADCN    = 8'd28,
        POS_ADD     = 8'd29,
        POS_F       = 8'd30,
        POS_B       = 8'd35,
        POS_C       = 8'd40,
        POS_CL      = 8'd42,
        POS_CM      = 8'd43,
        POS_CMODE   = 8'd44,
        POS_D       = 8'd45,
        POS_I       = 8'd50,
        POS_IN      = 8'd51,
        POS_INQ     = 8'd52,
        POS_INQM    = 8'd53,
        POS_IA      = 8'd57,
        POS_IP      = 8'd58,
        POS_M       = 8'd60,
        POS_MP      = 8'd61,
        POS_MR      = 8'd62,
        POS_N       = 8'd65,
        POS_P       = 8'd70,
        POS_PO      = 8'd71,
        POS_PS      = 8'd72,
        POS_R       = 8'd75,
        POS_RO      = 8'd76,
        POS_ROLE    = 8'd77,
        POS_RN      = 8'd78,
        POS_S       = 8'd80,
        POS_SE      = 8'd81,
        POS_SN      = 8'd82,
        POS_ST      = 8'd83,
        POS_U       = 8'd90,
        POS_V       = 8'd95,
        POS_COLLECT = 8'd200,
        POS_LF_WAIT = 8'd210,
        POS_TAIL    = 8'd230
    } pos_t;

    typedef struct packed {
        pos_t       pos;
        kind_t      kind;
        logic [7:0] err;
        logic       master;
    } parse_state_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic       done;
        kind_t      done_kind;
        logic       ack;
        logic       link_check;
        logic       fail_seen;
    } parse_event_t;

    // Hex digit value; a byte that is not an upper-case hex digit stands for itself.
    function automatic logic [7:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= "A" && c <= "F")
        begin
            v = c - 8'd55;
        end
        else if (c >= "0" && c <= "9")
        begin
            v = c - 8'd48;
        end
        return v;
    endfunction

endpackage

// ===== rtl/atrp_recognizer.sv =====
// Byte-wise reply recognizer: next parser state and events for one command-mode byte.
module atrp_recognizer (
    input  atrp_pkg::parse_state_t cur,
    input  logic [7:0]             c,
    output atrp_pkg::parse_state_t nxt,
    output atrp_pkg::parse_event_t ev
);
    import atrp_pkg::*;

    logic  col_en;
    kind_t col_kind;

    always_comb
    begin
        nxt      = cur;
        ev       = '0;
        col_en   = 1'b0;
        col_kind = KIND_NONE;

        case (cur.pos)
            POS_IDLE:
            begin
                if (c == "+")      nxt.pos = POS_PLUS;
                else if (c == "O") nxt.pos = POS_O;
                else if (c == "E") nxt.pos = POS_E;
                else if (c == "F") nxt.pos = POS_F;
            end
            POS_PLUS:
            begin
                case (c)
                    "A":     nxt.pos = POS_A;
                    "B":     nxt.pos = POS_B;
                    "C":     nxt.pos = POS_C;
                    "D":     nxt.pos = POS_D;
                    "I":     nxt.pos = POS_I;
                    "M":     nxt.pos = POS_M;
                    "N":     nxt.pos = POS_N;
                    "P":     nxt.pos = POS_P;
                    "R":     nxt.pos = POS_R;
                    "S":     nxt.pos = POS_S;
                    "U":     nxt.pos = POS_U;
                    "V":     nxt.pos = POS_V;
                    default: nxt.pos = POS_IDLE;
                endcase
            end
            POS_O:   nxt.pos = (c == "K") ? POS_OK : POS_IDLE;
            POS_OK:
            begin
                if (c == CHAR_CR)
                begin
                    nxt.pos  = POS_LF_WAIT;
                    nxt.kind = KIND_OK;
                end
                else
                begin
                    nxt.pos = POS_IDLE;
                end
            end
            POS_E:
            begin
                if (c == "(") nxt.pos = POS_ERR_D1;
            end
            POS_ERR_D1:
            begin
                nxt.err          = hex_nibble(c);
                ev.payload_valid = 1'b1;
                ev.payload_byte  = c;
                nxt.pos          = POS_ERR_D2;
            end
            POS_ERR_D2:
            begin
                if (c != ")")
                begin
                    nxt.err          = {cur.err[3:0], 4'h0} | hex_nibble(c);
                    ev.payload_valid = 1'b1;
                    ev.payload_byte  = c;
                end
                nxt.kind = KIND_ERROR;
                nxt.pos  = POS_TAIL;
            end
            POS_A:   nxt.pos = (c == "D") ? POS_AD : POS_IDLE;
            POS_AD:
            begin
                if (c == "C")      nxt.pos = POS_ADC;
                else if (c == "D") nxt.pos = POS_ADD;
                else               nxt.pos = POS_IDLE;
            end
            POS_ADC:
            begin
                if (c == ":") nxt.pos = POS_ADCN;
            end
            POS_ADCN:
            begin
                ev.payload_valid = 1'b1;
                ev.payload_byte  = c;
                nxt.kind         = KIND_ADCN;
                nxt.pos          = POS_TAIL;
            end
            POS_ADD:
            begin
                col_en   = 1'b1;
                col_kind = KIND_ADDR;
            end
            POS_F:
            begin
                // The byte right after F is swallowed; payload follows until CR.
                nxt.kind     = KIND_FAIL;
                nxt.pos      = POS_COLLECT;
                ev.fail_seen = 1'b1;
            end
            POS_B:
            begin
                col_en   = 1'b1;
                col_kind = KIND_BIND;
            end
            POS_C:
            begin
                if (c == "L")      nxt.pos = POS_CL;
                else if (c == "M") nxt.pos = POS_CM;
                else               nxt.pos = POS_IDLE;
            end
            POS_CL:
            begin
                col_en   = 1'b1;
                col_kind = KIND_CLASS;
            end
            POS_CM:
            begin
                if (c == ":") nxt.pos = POS_CMODE;
            end
            POS_CMODE:
            begin
                ev.payload_valid = 1'b1;
                ev.payload_byte  = c;
                nxt.kind         = KIND_CMODE;
                nxt.pos          = POS_TAIL;
            end
            POS_D:
            begin
                col_en   = 1'b1;
                col_kind = KIND_DISC;
            end
            POS_I:
            begin
                if (c == "N")      nxt.pos = POS_IN;
                else if (c == "A") nxt.pos = POS_IA;
                else if (c == "P") nxt.pos = POS_IP;
                else               nxt.pos = POS_IDLE;
            end
            POS_IN:  nxt.pos = (c == "Q") ? POS_INQ : POS_IDLE;
            POS_INQ:
            begin
                if (c == ":")
                begin
                    nxt.kind = KIND_INQ;
                    nxt.pos  = POS_COLLECT;
                end
                else if (c == "M")
                begin
                    nxt.pos = POS_INQM;
                end
                else
                begin
                    nxt.pos = POS_IDLE;
                end
            end
            POS_INQM:
            begin
                col_en   = 1'b1;
                col_kind = KIND_INQM;
            end
            POS_IA:
            begin
                col_en   = 1'b1;
                col_kind = KIND_IAC;
            end
            POS_IP:
            begin
                col_en   = 1'b1;
                col_kind = KIND_IPSCAN;
            end
            POS_M:
            begin
                if (c == "P")      nxt.pos = POS_MP;
                else if (c == "R") nxt.pos = POS_MR;
                else               nxt.pos = POS_IDLE;
            end
            POS_MP:
            begin
                col_en   = 1'b1;
                col_kind = KIND_MPIO;
            end
            POS_MR:
            begin
                col_en   = 1'b1;
                col_kind = KIND_MRAD;
            end
            POS_N:
            begin
                col_en   = 1'b1;
                col_kind = KIND_NAME;
            end
            POS_P:
            begin
                if (c == "O")      nxt.pos = POS_PO;
                else if (c == "S") nxt.pos = POS_PS;
                else               nxt.pos = POS_IDLE;
            end
            POS_PO:
            begin
                col_en   = 1'b1;
                col_kind = KIND_POLAR;
            end
            POS_PS:
            begin
                col_en   = 1'b1;
                col_kind = KIND_PSWD;
            end
            POS_R:
            begin
                if (c == "O")      nxt.pos = POS_RO;
                else if (c == "N") nxt.pos = POS_RN;
                else               nxt.pos = POS_IDLE;
            end
            POS_RO:
            begin
                if (c == ":") nxt.pos = POS_ROLE;
            end
            POS_ROLE:
            begin
                ev.payload_valid = 1'b1;
                ev.payload_byte  = c;
                nxt.master       = (c == "1");
                nxt.kind         = KIND_ROLE;
                nxt.pos          = POS_TAIL;
            end
            POS_RN:
            begin
                col_en   = 1'b1;
                col_kind = KIND_RNAME;
            end
            POS_S:
            begin
                if (c == "E")      nxt.pos = POS_SE;
                else if (c == "N") nxt.pos = POS_SN;
                else if (c == "T") nxt.pos = POS_ST;
                else               nxt.pos = POS_IDLE;
            end
            POS_SE:
            begin
                col_en   = 1'b1;
                col_kind = KIND_SENM;
            end
            POS_SN:
            begin
                col_en   = 1'b1;
                col_kind = KIND_SNIFF;
            end
            POS_ST:
            begin
                col_en   = 1'b1;
                col_kind = KIND_STATE;
            end
            POS_U:
            begin
                col_en   = 1'b1;
                col_kind = KIND_UART;
            end
            POS_V:
            begin
                col_en   = 1'b1;
                col_kind = KIND_VERSION;
            end
            POS_COLLECT:
            begin
                if (c == CHAR_CR)
                begin
                    nxt.pos = POS_LF_WAIT;
                end
                else
                begin
                    ev.payload_valid = 1'b1;
                    ev.payload_byte  = c;
                end
            end
            POS_LF_WAIT:
            begin
                if (c == CHAR_LF)
                begin
                    ev.done       = 1'b1;
                    ev.done_kind  = cur.kind;
                    ev.link_check = 1'b1;
                    ev.ack        = (cur.kind == KIND_OK);
                end
                nxt.pos = POS_IDLE;
            end
            POS_TAIL:
            begin
                if (c == CHAR_LF)
                begin
                    ev.done      = 1'b1;
                    ev.done_kind = cur.kind;
                    ev.ack       = (cur.kind == KIND_OK) || (cur.kind == KIND_ERROR);
                    nxt.pos      = POS_IDLE;
                end
            end
            default: nxt.pos = POS_IDLE;
        endcase

        // A keyword followed by a colon starts payload collection.
        if (col_en && c == ":")
        begin
            nxt.kind = col_kind;
            nxt.pos  = POS_COLLECT;
        end
    end

endmodule

// ===== rtl/at_response_parser.sv =====
// Top level of the AT reply parser: mode control, status-line edge and result register.
//
// Usage: the input channel (in_valid/in_ready) carries one item per transfer: op selects a
// serial tick, enter command mode, enter data mode or a link attempt mark; on a tick
// state_line is the module status level and byte_valid/rx_byte an optional received byte.
// A falling edge of the status line between two ticks forces command mode. In command
// mode each byte steps the reply recognizer; payload characters appear on payload_valid,
// and the closing line feed pulses response_done with response_kind (ack_seen as well for
// OK and ERROR). An OK line that ends while a link attempt is pending enters data mode,
// where every received byte is passed out on data_valid/data_byte.
// The output channel (out_valid/out_ready) carries exactly one result per input item,
// including error_code, master_role, link_mode and key_line as updated by that item.
// Registered result: an item accepted at one edge has its result in the output register
// after that edge. Throughput is one item per cycle, set by the single state update of
// the recognizer between the input port and the result register.
// If the receiver stalls, the result holds and in_ready stays low until it is taken; a
// new item is accepted in the same cycle that the waiting result is taken.
// Reset clears the parser to idle, the mode to undefined, the key line low, and empties
// the result register.
module at_response_parser (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] op,
    input  logic       state_line,
    input  logic       byte_valid,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       data_valid,
    output logic [7:0] data_byte,
    output logic       payload_valid,
    output logic [7:0] payload_byte,
    output logic       response_done,
    output logic [4:0] response_kind,
    output logic [7:0] error_code,
    output logic       ack_seen,
    output logic       master_role,
    output logic [1:0] link_mode,
    output logic       key_line
);
    import atrp_pkg::*;

    // Architectural state.
    parse_state_t st_reg, st_next;
    mode_t        mode_reg, mode_next;
    logic         line_prev_reg, line_prev_next;
    logic         link_pending_reg, link_pending_next;
    logic         key_reg, key_next;

    // Result register.
    logic       out_valid_reg;
    logic       dv_reg, dv_next;
    logic [7:0] db_reg, db_next;
    logic       pv_reg, pv_next;
    logic [7:0] pb_reg, pb_next;
    logic       done_reg, done_next;
    kind_t      kind_reg, kind_next;
    logic       ack_reg, ack_next;

    parse_state_t rec_state;
    parse_event_t rec_ev;
    logic         accept;

    atrp_recognizer u_recognizer (
        .cur (st_reg),
        .nxt (rec_state),
        .c   (rx_byte),
        .ev  (rec_ev)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        st_next           = st_reg;
        mode_next         = mode_reg;
        key_next          = key_reg;
        line_prev_next    = line_prev_reg;
        link_pending_next = link_pending_reg;
        dv_next   = 1'b0;
        db_next   = 8'h00;
        pv_next   = 1'b0;
        pb_next   = 8'h00;
        done_next = 1'b0;
        kind_next = KIND_NONE;
        ack_next  = 1'b0;

        case (op_t'(op))
            OP_CMD:
            begin
                mode_next = MODE_CMD;
                key_next  = 1'b1;
            end
            OP_DATA:
            begin
                mode_next = MODE_PASS;
                key_next  = 1'b0;
            end
            OP_LINK:
            begin
                link_pending_next = 1'b1;
            end
            OP_TICK:
            begin
                // A falling status line means the module dropped into command mode.
                if (line_prev_reg && !state_line)
                begin
                    mode_next = MODE_CMD;
                    key_next  = 1'b1;
                end
                line_prev_next = state_line;
                if (byte_valid)
                begin
                    if (mode_next == MODE_CMD)
                    begin
                        st_next   = rec_state;
                        pv_next   = rec_ev.payload_valid;
                        pb_next   = rec_ev.payload_byte;
                        done_next = rec_ev.done;
                        kind_next = rec_ev.done_kind;
                        ack_next  = rec_ev.ack;
                        if (rec_ev.fail_seen)
                        begin
                            link_pending_next = 1'b0;
                        end
                        // A completed OK reply while a link is pending means connected.
                        if (rec_ev.link_check && link_pending_next)
                        begin
                            link_pending_next = 1'b0;
                            if (rec_ev.done_kind == KIND_OK)
                            begin
                                mode_next = MODE_PASS;
                                key_next  = 1'b0;
                            end
                        end
                    end
                    // The line feed that enters data mode is passed out as data too.
                    if (mode_next == MODE_PASS)
                    begin
                        dv_next = 1'b1;
                        db_next = rx_byte;
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg           <= '{pos: POS_IDLE, kind: KIND_NONE, err: 8'h00, master: 1'b0};
            mode_reg         <= MODE_UNSET;
            line_prev_reg    <= 1'b0;
            link_pending_reg <= 1'b0;
            key_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                st_reg           <= st_next;
                mode_reg         <= mode_next;
                line_prev_reg    <= line_prev_next;
                link_pending_reg <= link_pending_next;
                key_reg          <= key_next;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dv_reg   <= dv_next;
            db_reg   <= db_next;
            pv_reg   <= pv_next;
            pb_reg   <= pb_next;
            done_reg <= done_next;
            kind_reg <= kind_next;
            ack_reg  <= ack_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign data_valid    = dv_reg;
    assign data_byte     = db_reg;
    assign payload_valid = pv_reg;
    assign payload_byte  = pb_reg;
    assign response_done = done_reg;
    assign response_kind = kind_reg;
    assign ack_seen      = ack_reg;
    // Status fields reflect the state left by the item whose result is shown.
    assign error_code    = st_reg.err;
    assign master_role   = st_reg.master;
    assign link_mode     = mode_reg;
    assign key_line      = key_reg;

    a_kind_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !done_reg |-> kind_reg == KIND_NONE)
        else $error("response_kind set without response_done");

    a_data_only_in_data_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && dv_reg |-> mode_reg == MODE_PASS && !pv_reg)
        else $error("data byte outside data mode or alongside payload");

    a_key_follows_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg != MODE_CMD || key_reg) && (mode_reg != MODE_PASS || !key_reg))
        else $error("key line disagrees with link mode");

    a_ack_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ack_reg |->
            done_reg && (kind_reg == KIND_OK || kind_reg == KIND_ERROR))
        else $error("ack without completed OK or ERROR reply");

endmodule

// ===== test/tb_at_response_parser.sv =====
// Self-checking testbench for the AT reply parser: directed and random traffic against a predictor.
`timescale 1ns / 1ps

module tb_at_response_parser;

    import atrp_pkg::*;

    // The run is stopped here even if the block never drains.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_LIMIT = 40;

    // One result transfer, field by field, as the output port presents it.
    typedef struct packed {
        logic       dv;
        logic [7:0] db;
        logic       pv;
        logic [7:0] pb;
        logic       done;
        kind_t      kind;
        logic [7:0] err;
        logic       ack;
        logic       master;
        mode_t      mode;
        logic       key;
    } parser_result_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    op_t        op;
    logic       state_line;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       out_valid;
    logic       out_ready;
    logic       data_valid;
    logic [7:0] data_byte;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic       response_done;
    logic [4:0] response_kind;
    logic [7:0] error_code;
    logic       ack_seen;
    logic       master_role;
    logic [1:0] link_mode;
    logic       key_line;

    // Predictor copy of the parser state, advanced once per accepted input transfer.
    pos_t       rec_pos;
    kind_t      rec_kind;
    logic [7:0] rec_err;
    logic       rec_master;
    mode_t      mode_now;
    logic       line_was;
    logic       link_armed;
    logic       key_now;

    // Results still owed by the block, oldest first.
    parser_result_t results_due[$];

    // Stimulus and bookkeeping.
    logic        steady;        // when set, neither side idles
    logic        line_level;    // status line level used for byte ticks
    int unsigned items_sent;
    int unsigned results_checked;
    int unsigned replies_done;
    int unsigned data_seen;
    int unsigned mismatches;
    int unsigned cycle_count;
    logic [25:0] kinds_hit;

    at_response_parser dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .state_line    (state_line),
        .byte_valid    (byte_valid),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .data_valid    (data_valid),
        .data_byte     (data_byte),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .response_done (response_done),
        .response_kind (response_kind),
        .error_code    (error_code),
        .ack_seen      (ack_seen),
        .master_role   (master_role),
        .link_mode     (link_mode),
        .key_line      (key_line)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Changing the mode also moves the key pin: high for command mode, low for data mode.
    function automatic void enter_mode(input mode_t m);
        mode_now = m;
        if (m == MODE_PASS)
        begin
            key_now = 1'b0;
        end
        if (m == MODE_CMD)
        begin
            key_now = 1'b1;
        end
    endfunction

    // Upper-case hex digits give their value; any other byte stands for itself.
    function automatic logic [7:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = c;
        if (c >= "0" && c <= "9")
        begin
            v = c - "0";
        end
        else if (c >= "A" && c <= "F")
        begin
            v = c - "A" + 8'd10;
        end
        return v;
    endfunction

    // A keyword is complete once its colon arrives; anything before the colon is skipped.
    function automatic void expect_colon(input logic [7:0] c, input kind_t k);
        if (c == ":")
        begin
            rec_kind = k;
            rec_pos  = POS_COLLECT;
        end
    endfunction

    // Advances the predictor by one input transfer and returns the result it must cause.
    function automatic parser_result_t predict_parse(input op_t o, input logic line,
                                                     input logic bv, input logic [7:0] c);
        parser_result_t r;
        r = '0;
        case (o)
            OP_CMD:  enter_mode(MODE_CMD);
            OP_DATA: enter_mode(MODE_PASS);
            OP_LINK: link_armed = 1'b1;
            default:
            begin
                // A falling status line forces command mode before the byte is looked at.
                if (line_was && !line)
                begin
                    enter_mode(MODE_CMD);
                end
                line_was = line;
                if (bv && mode_now == MODE_CMD)
                begin
                    case (rec_pos)
                        POS_IDLE:
                        begin
                            if (c == "+")
                                rec_pos = POS_PLUS;
                            else if (c == "O")
                                rec_pos = POS_O;
                            else if (c == "E")
                                rec_pos = POS_E;
                            else if (c == "F")
                                rec_pos = POS_F;
                        end
                        POS_PLUS:
                        begin
                            case (c)
                                "A":     rec_pos = POS_A;
                                "B":     rec_pos = POS_B;
                                "C":     rec_pos = POS_C;
                                "D":     rec_pos = POS_D;
                                "I":     rec_pos = POS_I;
                                "M":     rec_pos = POS_M;
                                "N":     rec_pos = POS_N;
                                "P":     rec_pos = POS_P;
                                "R":     rec_pos = POS_R;
                                "S":     rec_pos = POS_S;
                                "U":     rec_pos = POS_U;
                                "V":     rec_pos = POS_V;
                                default: rec_pos = POS_IDLE;
                            endcase
                        end
                        POS_O: rec_pos = (c == "K") ? POS_OK : POS_IDLE;
                        POS_OK:
                        begin
                            if (c == CHAR_CR)
                            begin
                                rec_pos  = POS_LF_WAIT;
                                rec_kind = KIND_OK;
                            end
                            else
                            begin
                                rec_pos = POS_IDLE;
                            end
                        end
                        POS_E:
                        begin
                            if (c == "(")
                            begin
                                rec_pos = POS_ERR_D1;
                            end
                        end
                        POS_ERR_D1:
                        begin
                            rec_err = hex_value(c);
                            r.pv    = 1'b1;
                            r.pb    = c;
                            rec_pos = POS_ERR_D2;
                        end
                        POS_ERR_D2:
                        begin
                            // A closing bracket here means the code had a single digit.
                            if (c != ")")
                            begin
                                rec_err = {rec_err[3:0], 4'h0} | hex_value(c);
                                r.pv    = 1'b1;
                                r.pb    = c;
                            end
                            rec_kind = KIND_ERROR;
                            rec_pos  = POS_TAIL;
                        end
                        POS_A: rec_pos = (c == "D") ? POS_AD : POS_IDLE;
                        POS_AD:
                        begin
                            if (c == "C")
                                rec_pos = POS_ADC;
                            else if (c == "D")
                                rec_pos = POS_ADD;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_ADC:
                        begin
                            if (c == ":")
                            begin
                                rec_pos = POS_ADCN;
                            end
                        end
                        POS_ADCN:
                        begin
                            r.pv     = 1'b1;
                            r.pb     = c;
                            rec_kind = KIND_ADCN;
                            rec_pos  = POS_TAIL;
                        end
                        POS_ADD: expect_colon(c, KIND_ADDR);
                        POS_F:
                        begin
                            // The letter after F is swallowed and a pending link attempt failed.
                            rec_kind   = KIND_FAIL;
                            rec_pos    = POS_COLLECT;
                            link_armed = 1'b0;
                        end
                        POS_B: expect_colon(c, KIND_BIND);
                        POS_C:
                        begin
                            if (c == "L")
                                rec_pos = POS_CL;
                            else if (c == "M")
                                rec_pos = POS_CM;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_CL: expect_colon(c, KIND_CLASS);
                        POS_CM:
                        begin
                            if (c == ":")
                            begin
                                rec_pos = POS_CMODE;
                            end
                        end
                        POS_CMODE:
                        begin
                            r.pv     = 1'b1;
                            r.pb     = c;
                            rec_kind = KIND_CMODE;
                            rec_pos  = POS_TAIL;
                        end
                        POS_D: expect_colon(c, KIND_DISC);
                        POS_I:
                        begin
                            if (c == "N")
                                rec_pos = POS_IN;
                            else if (c == "A")
                                rec_pos = POS_IA;
                            else if (c == "P")
                                rec_pos = POS_IP;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_IN: rec_pos = (c == "Q") ? POS_INQ : POS_IDLE;
                        POS_INQ:
                        begin
                            if (c == ":")
                            begin
                                rec_kind = KIND_INQ;
                                rec_pos  = POS_COLLECT;
                            end
                            else if (c == "M")
                            begin
                                rec_pos = POS_INQM;
                            end
                            else
                            begin
                                rec_pos = POS_IDLE;
                            end
                        end
                        POS_INQM: expect_colon(c, KIND_INQM);
                        POS_IA:   expect_colon(c, KIND_IAC);
                        POS_IP:   expect_colon(c, KIND_IPSCAN);
                        POS_M:
                        begin
                            if (c == "P")
                                rec_pos = POS_MP;
                            else if (c == "R")
                                rec_pos = POS_MR;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_MP: expect_colon(c, KIND_MPIO);
                        POS_MR: expect_colon(c, KIND_MRAD);
                        POS_N:  expect_colon(c, KIND_NAME);
                        POS_P:
                        begin
                            if (c == "O")
                                rec_pos = POS_PO;
                            else if (c == "S")
                                rec_pos = POS_PS;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_PO: expect_colon(c, KIND_POLAR);
                        POS_PS: expect_colon(c, KIND_PSWD);
                        POS_R:
                        begin
                            if (c == "O")
                                rec_pos = POS_RO;
                            else if (c == "N")
                                rec_pos = POS_RN;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_RO:
                        begin
                            if (c == ":")
                            begin
                                rec_pos = POS_ROLE;
                            end
                        end
                        POS_ROLE:
                        begin
                            r.pv       = 1'b1;
                            r.pb       = c;
                            rec_master = (c == "1");
                            rec_kind   = KIND_ROLE;
                            rec_pos    = POS_TAIL;
                        end
                        POS_RN: expect_colon(c, KIND_RNAME);
                        POS_S:
                        begin
                            if (c == "E")
                                rec_pos = POS_SE;
                            else if (c == "N")
                                rec_pos = POS_SN;
                            else if (c == "T")
                                rec_pos = POS_ST;
                            else
                                rec_pos = POS_IDLE;
                        end
                        POS_SE: expect_colon(c, KIND_SENM);
                        POS_SN: expect_colon(c, KIND_SNIFF);
                        POS_ST: expect_colon(c, KIND_STATE);
                        POS_U:  expect_colon(c, KIND_UART);
                        POS_V:  expect_colon(c, KIND_VERSION);
                        POS_COLLECT:
                        begin
                            if (c == CHAR_CR)
                            begin
                                rec_pos = POS_LF_WAIT;
                            end
                            else
                            begin
                                r.pv = 1'b1;
                                r.pb = c;
                            end
                        end
                        POS_LF_WAIT:
                        begin
                            // An OK that closes while a link attempt is pending opens data mode.
                            if (c == CHAR_LF)
                            begin
                                r.done = 1'b1;
                                r.kind = rec_kind;
                                if (link_armed)
                                begin
                                    link_armed = 1'b0;
                                    if (rec_kind == KIND_OK)
                                    begin
                                        enter_mode(MODE_PASS);
                                    end
                                end
                                r.ack = (rec_kind == KIND_OK);
                            end
                            rec_pos = POS_IDLE;
                        end
                        POS_TAIL:
                        begin
                            if (c == CHAR_LF)
                            begin
                                r.done  = 1'b1;
                                r.kind  = rec_kind;
                                r.ack   = (rec_kind == KIND_OK || rec_kind == KIND_ERROR);
                                rec_pos = POS_IDLE;
                            end
                        end
                        default: rec_pos = POS_IDLE;
                    endcase
                end
                // Checked after the recognizer, so the line feed that opens data mode
                // is passed out as data as well.
                if (bv && mode_now == MODE_PASS)
                begin
                    r.dv = 1'b1;
                    r.db = c;
                end
            end
        endcase
        r.err    = rec_err;
        r.master = rec_master;
        r.mode   = mode_now;
        r.key    = key_now;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sending side
    // ------------------------------------------------------------------

    // Presents one input transfer and holds it until the block takes it. Called and
    // returning at a falling edge; the valid line is left high for a following item.
    task automatic send_item(input op_t o, input logic line, input logic bv,
                             input logic [7:0] c);
        while (!steady && $urandom_range(99) < 7)
        begin
            // Idle cycle: junk on the payload ports must be ignored.
            in_valid <= 1'b0;
            rx_byte  <= 8'($urandom_range(255));
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        state_line <= line;
        byte_valid <= bv;
        rx_byte    <= c;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        results_due.push_back(predict_parse(o, line, bv, c));
        items_sent++;
        if (o == OP_TICK)
        begin
            line_level = line;
        end
        @(negedge clk);
    endtask

    // A received byte at the current status line level, now and then after an empty tick.
    task automatic send_byte(input logic [7:0] c);
        if ($urandom_range(99) < 4)
        begin
            send_item(OP_TICK, line_level, 1'b0, 8'($urandom_range(255)));
        end
        send_item(OP_TICK, line_level, 1'b1, c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i]);
        end
    endtask

    // Control items carry random, meaningless line and byte fields.
    task automatic send_control(input op_t o);
        send_item(o, 1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    // Lowers valid and waits until every owed result has been taken.
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Mostly printable payload characters; the carriage return is left out so that
    // the line runs to its intended end.
    function automatic logic [7:0] payload_char();
        logic [7:0] c;
        if ($urandom_range(99) < 85)
        begin
            c = 8'($urandom_range(32, 126));
        end
        else
        begin
            c = 8'($urandom_range(255));
            if (c == CHAR_CR)
            begin
                c = 8'hFF;
            end
        end
        return c;
    endfunction

    function automatic string reply_word(input kind_t k);
        case (k)
            KIND_OK:      return "OK";
            KIND_ERROR:   return "ERROR:(";
            KIND_FAIL:    return "FAIL";
            KIND_ADCN:    return "+ADCN:";
            KIND_ADDR:    return "+ADDR:";
            KIND_BIND:    return "+BIND:";
            KIND_CLASS:   return "+CLASS:";
            KIND_CMODE:   return "+CMODE:";
            KIND_DISC:    return "+DISC:";
            KIND_INQ:     return "+INQ:";
            KIND_INQM:    return "+INQM:";
            KIND_IAC:     return "+IAC:";
            KIND_IPSCAN:  return "+IPSCAN:";
            KIND_MPIO:    return "+MPIO:";
            KIND_MRAD:    return "+MRAD:";
            KIND_NAME:    return "+NAME:";
            KIND_POLAR:   return "+POLAR:";
            KIND_PSWD:    return "+PSWD:";
            KIND_ROLE:    return "+ROLE:";
            KIND_RNAME:   return "+RNAME:";
            KIND_SENM:    return "+SENM:";
            KIND_SNIFF:   return "+SNIFF:";
            KIND_STATE:   return "+STATE:";
            KIND_UART:    return "+UART:";
            KIND_VERSION: return "+VERSION:";
            default:      return "";
        endcase
    endfunction

    // Sends one reply line of the given kind with random content. A broken reply is cut
    // short at a random point and may end in a stray byte.
    task automatic send_reply(input kind_t k, input logic whole);
        logic [7:0]  seq[$];
        string       word;
        string       hex_digits;
        int unsigned n;
        word       = reply_word(k);
        hex_digits = "0123456789ABCDEF";
        for (int i = 0; i < word.len(); i++)
        begin
            seq.push_back(word[i]);
        end
        case (k)
            KIND_OK:
            begin
            end
            KIND_ERROR:
            begin
                // Mostly hex digits, sometimes a byte that is not a digit at all.
                for (int d = 0; d < 2; d++)
                begin
                    if (d == 0 || $urandom_range(1))
                    begin
                        if ($urandom_range(99) < 75)
                            seq.push_back(hex_digits[$urandom_range(15)]);
                        else
                            seq.push_back(payload_char());
                    end
                end
                seq.push_back(")");
            end
            KIND_ADCN, KIND_CMODE:
            begin
                seq.push_back(payload_char());
            end
            KIND_ROLE:
            begin
                if ($urandom_range(99) < 80)
                    seq.push_back($urandom_range(1) ? "1" : "0");
                else
                    seq.push_back(payload_char());
            end
            default:
            begin
                n = $urandom_range(6);
                repeat (n)
                begin
                    seq.push_back(payload_char());
                end
            end
        endcase
        seq.push_back(CHAR_CR);
        seq.push_back(CHAR_LF);
        if (!whole)
        begin
            n = $urandom_range(seq.size() - 1, 1);
            while (seq.size() > n)
            begin
                void'(seq.pop_back());
            end
            if ($urandom_range(1))
            begin
                seq.push_back(8'($urandom_range(255)));
            end
        end
        foreach (seq[i])
        begin
            send_byte(seq[i]);
        end
    endtask

    // Leaves data or undefined mode by a control item or by a falling status line.
    task automatic return_to_command();
        if ($urandom_range(1))
        begin
            send_control(OP_CMD);
        end
        else
        begin
            if (!line_level)
            begin
                send_item(OP_TICK, 1'b1, 1'b0, 8'($urandom_range(255)));
            end
            // The byte on the falling tick is already parsed in command mode.
            send_item(OP_TICK, 1'b0, 1'($urandom_range(1)), "O");
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Short walk through the extremes, every operation and each special case.
    task automatic test_directed();
        // Undefined mode after reset: even an all-ones byte is dropped.
        send_item(OP_TICK, 1'b1, 1'b1, 8'hFF);
        // The status line falls on an empty tick and forces command mode.
        send_item(OP_TICK, 1'b0, 1'b0, 8'h00);
        // A link attempt followed by OK opens data mode; the closing line feed is data too.
        send_control(OP_LINK);
        send_text("OK");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'h00);
        send_control(OP_CMD);
        // ERROR with a first digit that is not hex; the code keeps only the low nibble of that byte.
        send_text("E(zF");
        send_byte(CHAR_LF);
        // Unknown letter after M drops back to idle.
        send_text("+MX");
        // FAIL: the letter after F is swallowed, the rest up to the return is payload.
        send_text("FxQ");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        // ROLE of 1 sets the master flag.
        send_text("+RO:1");
        send_byte(CHAR_LF);
        send_control(OP_DATA);
        send_byte(8'hFF);
        send_control(OP_CMD);
    endtask

    // Mostly well-formed replies with random content, plus link attempts, data bursts,
    // broken replies and plain noise.
    task automatic test_random_traffic(input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned n;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            if (mode_now != MODE_CMD)
            begin
                return_to_command();
            end
            pick = $urandom_range(99);
            if (pick < 58)
            begin
                send_reply(kind_t'($urandom_range(25, 1)), 1'b1);
            end
            else if (pick < 72)
            begin
                send_control(OP_LINK);
                send_reply(KIND_OK, 1'b1);
                n = $urandom_range(6, 1);
                repeat (n)
                begin
                    send_byte(8'($urandom_range(255)));
                end
            end
            else if (pick < 78)
            begin
                // A link attempt that fails or is answered by an error stays in command mode.
                send_control(OP_LINK);
                send_reply($urandom_range(1) ? KIND_FAIL : KIND_ERROR, 1'b1);
            end
            else if (pick < 88)
            begin
                send_reply(kind_t'($urandom_range(25, 1)), 1'b0);
            end
            else if (pick < 93)
            begin
                // A plus sign followed by any capital letter, known or not.
                send_byte("+");
                send_byte(8'($urandom_range("Z", "A")));
            end
            else
            begin
                n = $urandom_range(4, 1);
                repeat (n)
                begin
                    send_item(op_t'($urandom_range(3)), 1'($urandom_range(1)),
                              1'($urandom_range(1)), 8'($urandom_range(255)));
                end
            end
        end
    endtask

    // The same traffic with no idling on either side, so items arrive back to back.
    task automatic test_back_to_back(input int unsigned n_items);
        steady = 1'b1;
        test_random_traffic(n_items);
        wait_drain();
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiving side and checks
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        out_ready <= steady || ($urandom_range(99) >= 7);
    end

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        end
    endfunction

    // Each result transfer is matched against the oldest owed result.
    always @(posedge clk)
    begin : result_check
        parser_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (results_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: result transfer with nothing owed, expected none, actual kind %0h",
                         $time, response_kind);
            end
            else
            begin
                want = results_due.pop_front();
                check_field("data_valid", 8'(want.dv), 8'(data_valid));
                check_field("data_byte", want.db, data_byte);
                check_field("payload_valid", 8'(want.pv), 8'(payload_valid));
                check_field("payload_byte", want.pb, payload_byte);
                check_field("response_done", 8'(want.done), 8'(response_done));
                check_field("response_kind", 8'(want.kind), 8'(response_kind));
                check_field("error_code", want.err, error_code);
                check_field("ack_seen", 8'(want.ack), 8'(ack_seen));
                check_field("master_role", 8'(want.master), 8'(master_role));
                check_field("link_mode", 8'(want.mode), 8'(link_mode));
                check_field("key_line", 8'(want.key), 8'(key_line));
                results_checked++;
            end
            if (response_done === 1'b1)
            begin
                replies_done++;
                kinds_hit[response_kind] = 1'b1;
            end
            if (data_valid === 1'b1)
            begin
                data_seen++;
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d results still owed", $time, results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        op              = OP_TICK;
        state_line      = 1'b0;
        byte_valid      = 1'b0;
        rx_byte         = 8'h00;
        out_ready       = 1'b0;
        steady          = 1'b0;
        line_level      = 1'b0;
        items_sent      = 0;
        results_checked = 0;
        replies_done    = 0;
        data_seen       = 0;
        mismatches      = 0;
        cycle_count     = 0;
        kinds_hit       = '0;

        // Predictor state after reset.
        rec_pos    = POS_IDLE;
        rec_kind   = KIND_NONE;
        rec_err    = 8'h00;
        rec_master = 1'b0;
        mode_now   = MODE_UNSET;
        line_was   = 1'b0;
        link_armed = 1'b0;
        key_now    = 1'b0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        // The sender holds off here until every owed result has come back.
        wait_drain();
        test_random_traffic(300);
        wait_drain();
        test_back_to_back(80);

        // The results are registered; the wait lets any stray transfer show up.
        repeat (4) @(posedge clk);
        if (results_due.size() != 0)
        begin
            mismatches++;
            $display("%0t: results never delivered, expected 0 owed, actual %0d",
                     $time, results_due.size());
        end

        $display("Covered %0d input transfers and %0d result transfers, with %0d data bytes.",
                 items_sent, results_checked, data_seen);
        $display("Completed %0d replies spanning %0d of the 25 reply kinds; %0d mismatches.",
                 replies_done, $countones(kinds_hit[25:1]), mismatches);
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
